// ===== rtl/tcts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the toy CPU time slice unit.
// No dependencies; imported by the top level and its checker.

package tcts_pkg;

   localparam int MEM_WORDS = 128;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int REG_COUNT = 8;
   localparam int RF_AW     = $clog2(REG_COUNT);
   localparam int SLICE_LEN = 3;
   localparam int SLICE_CW  = (SLICE_LEN > 1) ? $clog2(SLICE_LEN) : 1;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 152;
   localparam int CSR_DATA_W  = 8;

   localparam logic [3:0] SEL_PC  = 4'(REG_COUNT);
   localparam logic [3:0] SEL_ACC = 4'(REG_COUNT + 1);

   typedef enum logic [1:0] {
      CMD_WMEM = 2'd0,
      CMD_WREG = 2'd1,
      CMD_RREG = 2'd2,
      CMD_RUN  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_DONE  = 3'd0,
      ST_CLOCK = 3'd1,
      ST_SEGV  = 3'd2,
      ST_ILL   = 3'd3,
      ST_SYSC  = 3'd4
   } status_type;

   localparam logic CSR_SEG_BASE = 1'b0;
   localparam logic CSR_SEG_SIZE = 1'b1;

   localparam logic [7:0] OP_ADD  = 8'd0;
   localparam logic [7:0] OP_SUB  = 8'd1;
   localparam logic [7:0] OP_CMP  = 8'd2;
   localparam logic [7:0] OP_IFGT = 8'd3;
   localparam logic [7:0] OP_NOP  = 8'd4;
   localparam logic [7:0] OP_JUMP = 8'd5;
   localparam logic [7:0] OP_HALT = 8'd6;
   localparam logic [7:0] OP_SYSC = 8'd7;
   localparam logic [7:0] OP_LOAD = 8'd8;

endpackage

// ===== rtl/toy_cpu_time_slice_unit.sv =====
`timescale 1ns / 1ps
// Toy CPU time slice unit: command sequencer around a word memory and a register file.
// Depends on tcts_pkg.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+--------------------------------------------
//  req     | in  | req_tvalid/tready   | command, mem_address, reg_index, write_value
//  rsp     | out | rsp_tvalid/tready   | status, read_value, pc_out, acc_out,
//          |     |                     | syscall_code, syscall_value
//  csr     | in  | csr_we              | segment_base (index 0), segment_size (1)
//
// Steps: memory or register writes and reads of PC/ACC pass from the accepted request
// through the response state into the output register; a data register read passes a
// register-read state first. A run slice steps each instruction through fetch, decode,
// operand and execute, plus load wait for LOAD; fetch and load share the one read port.
// One command is in flight at a time; the next is taken once the result sits in the
// output register, even if the consumer is stalling it.
// Reset (synchronous, active high) clears PC, ACC, segment base and register file valid
// bits (data registers read zero) and sets segment size to MEM_WORDS; memory is not cleared.

module toy_cpu_time_slice_unit (
   input  logic                               clock,
   input  logic                               reset,
   // command[1:0], mem_address[8:2], reg_index[12:9], write_value[44:13], zero pad
   input  logic [tcts_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // status[2:0], read_value[34:3], pc_out[66:35], acc_out[98:67],
   // syscall_code[114:99], syscall_value[146:115], zero pad
   output logic [tcts_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [tcts_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import tcts_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_RDREG  = 8'b0000_0010,
      S_FETCH  = 8'b0000_0100,
      S_DECODE = 8'b0000_1000,
      S_OPER   = 8'b0001_0000,
      S_EXEC   = 8'b0010_0000,
      S_LDWAIT = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   // request fields
   cmd_type            req_cmd;
   logic [MEM_AW-1:0]  req_addr;
   logic [3:0]         req_sel;
   logic [31:0]        req_val;

   assign req_cmd  = cmd_type'(req_tdata[1:0]);
   assign req_addr = req_tdata[8:2];
   assign req_sel  = req_tdata[12:9];
   assign req_val  = req_tdata[44:13];

   // control and architectural state
   state_type             state_ff, state_in;
   logic [SLICE_CW-1:0]   n_ff, n_in;
   logic [31:0]           pc_ff, pc_in;
   logic [31:0]           acc_ff, acc_in;
   logic [MEM_AW-1:0]     seg_base_ff;
   logic [7:0]            seg_size_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [REG_COUNT-1:0]  rf_valid_ff;

   // per-command working registers (no reset needed)
   status_type            status_ff, status_in;
   logic [31:0]           rd_ff, rd_in;
   logic [15:0]           scode_ff, scode_in;
   logic [31:0]           sval_ff, sval_in;
   logic [7:0]            op_ff, op_in;
   logic [RF_AW-1:0]      ri_ff, ri_in;
   logic [31:0]           arg_ff, arg_in;
   logic [31:0]           sum_ff, sum_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // word memory: one write, one registered read
   logic [31:0]        mem [MEM_WORDS];
   logic               mem_we, mem_re;
   logic [MEM_AW-1:0]  mem_wa, mem_ra;
   logic [31:0]        mem_wd, mem_q;

   // register file: one write, two registered reads
   logic [31:0]        rf [REG_COUNT];
   logic               rf_we, rf_re;
   logic [RF_AW-1:0]   rf_wa, rf_ra_a, rf_ra_b;
   logic [31:0]        rf_wd, rf_qa, rf_qb;
   logic               rf_va, rf_vb;
   logic [31:0]        ri_val, rj_val;

   assign ri_val = rf_va ? rf_qa : 32'd0;
   assign rj_val = rf_vb ? rf_qb : 32'd0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf[rf_wa] <= rf_wd;
      end
      if (rf_re) begin
         rf_qa <= rf[rf_ra_a];
         rf_qb <= rf[rf_ra_b];
         rf_va <= rf_valid_ff[rf_ra_a];
         rf_vb <= rf_valid_ff[rf_ra_b];
      end
   end

   // offset outside segment: negative or not below the size
   function automatic logic out_of_seg(input logic [31:0] off, input logic [7:0] size);
      out_of_seg = off[31] || (off[30:0] >= {23'd0, size});
   endfunction

   logic        res_free;
   logic [31:0] ex_diff;
   logic [31:0] ex_add;
   logic        acc_pos;
   logic        last_insn;

   assign res_free  = !rsp_valid_ff || rsp_tready;
   assign ex_add    = ri_val + sum_ff;
   assign ex_diff   = ri_val - sum_ff;
   assign acc_pos   = !acc_ff[31] && (acc_ff != 32'd0);
   assign last_insn = (n_ff == SLICE_CW'(SLICE_LEN - 1));

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      pc_in        = pc_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      scode_in     = scode_ff;
      sval_in      = sval_ff;
      op_in        = op_ff;
      ri_in        = ri_ff;
      arg_in       = arg_ff;
      sum_in       = sum_ff;
      rsp_data_in  = rsp_data_ff;

      mem_we  = 1'b0;
      mem_wa  = req_addr;
      mem_wd  = req_val;
      mem_re  = 1'b0;
      mem_ra  = pc_ff[MEM_AW-1:0] + seg_base_ff;
      rf_we   = 1'b0;
      rf_wa   = req_sel[RF_AW-1:0];
      rf_wd   = req_val;
      rf_re   = 1'b0;
      rf_ra_a = req_sel[RF_AW-1:0];
      rf_ra_b = req_sel[RF_AW-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               status_in = ST_DONE;
               rd_in     = 32'd0;
               scode_in  = 16'd0;
               sval_in   = 32'd0;
               n_in      = '0;
               state_in  = S_RESP;
               unique case (req_cmd)
                  CMD_WMEM: begin
                     mem_we = 1'b1;
                  end
                  CMD_WREG: begin
                     if (req_sel < SEL_PC) begin
                        rf_we = 1'b1;
                     end else if (req_sel == SEL_PC) begin
                        pc_in = req_val;
                     end else if (req_sel == SEL_ACC) begin
                        acc_in = req_val;
                     end
                  end
                  CMD_RREG: begin
                     if (req_sel < SEL_PC) begin
                        rf_re    = 1'b1;
                        state_in = S_RDREG;
                     end else if (req_sel == SEL_PC) begin
                        rd_in = pc_ff;
                     end else if (req_sel == SEL_ACC) begin
                        rd_in = acc_ff;
                     end
                  end
                  CMD_RUN: begin
                     status_in = ST_CLOCK;
                     state_in  = S_FETCH;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_RDREG: begin
            rd_in    = ri_val;
            state_in = S_RESP;
         end
         S_FETCH: begin
            if (out_of_seg(pc_ff, seg_size_ff)) begin
               status_in = ST_SEGV;
               state_in  = S_RESP;
            end else begin
               mem_re   = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            op_in    = mem_q[31:24];
            ri_in    = mem_q[20 +: RF_AW];
            arg_in   = {{16{mem_q[15]}}, mem_q[15:0]};
            rf_re    = 1'b1;
            rf_ra_a  = mem_q[20 +: RF_AW];
            rf_ra_b  = mem_q[16 +: RF_AW];
            state_in = S_OPER;
         end
         S_OPER: begin
            sum_in   = rj_val + arg_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = last_insn ? S_RESP : S_FETCH;
            n_in     = n_ff + SLICE_CW'(1);
            pc_in    = pc_ff + 32'd1;
            unique case (op_ff) inside
               OP_ADD: begin
                  rf_we  = 1'b1;
                  rf_wa  = ri_ff;
                  rf_wd  = ex_add;
                  acc_in = ex_add;
               end
               OP_SUB: begin
                  rf_we  = 1'b1;
                  rf_wa  = ri_ff;
                  rf_wd  = ex_diff;
                  acc_in = ex_diff;
               end
               OP_CMP: begin
                  acc_in = ex_diff;
               end
               OP_IFGT: begin
                  if (acc_pos) begin
                     pc_in = arg_ff;
                  end
               end
               OP_NOP, OP_HALT: begin
                  pc_in = pc_ff + 32'd1;
               end
               OP_JUMP: begin
                  pc_in = arg_ff;
               end
               OP_SYSC: begin
                  status_in = ST_SYSC;
                  scode_in  = arg_ff[15:0];
                  sval_in   = ri_val;
                  state_in  = S_RESP;
               end
               OP_LOAD: begin
                  // count advances once the loaded word is back
                  n_in   = n_ff;
                  acc_in = sum_ff;
                  pc_in  = pc_ff;
                  if (out_of_seg(sum_ff, seg_size_ff)) begin
                     status_in = ST_SEGV;
                     state_in  = S_RESP;
                  end else begin
                     mem_re   = 1'b1;
                     mem_ra   = sum_ff[MEM_AW-1:0] + seg_base_ff;
                     state_in = S_LDWAIT;
                  end
               end
               default: begin
                  // illegal opcode: slice ends, PC stays
                  pc_in     = pc_ff;
                  status_in = ST_ILL;
                  state_in  = S_RESP;
               end
            endcase
         end
         S_LDWAIT: begin
            acc_in   = mem_q;
            rf_we    = 1'b1;
            rf_wa    = ri_ff;
            rf_wd    = mem_q;
            pc_in    = pc_ff + 32'd1;
            n_in     = n_ff + SLICE_CW'(1);
            state_in = last_insn ? S_RESP : S_FETCH;
         end
         S_RESP: begin
            if (res_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, sval_ff, scode_ff, acc_ff, pc_ff, rd_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         pc_ff        <= 32'd0;
         acc_ff       <= 32'd0;
         seg_base_ff  <= '0;
         seg_size_ff  <= 8'(MEM_WORDS);
         rsp_valid_ff <= 1'b0;
         rf_valid_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rf_we) begin
            rf_valid_ff[rf_wa] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_SEG_BASE: seg_base_ff <= csr_wdata[MEM_AW-1:0];
               CSR_SEG_SIZE: seg_size_ff <= csr_wdata;
               default:      seg_size_ff <= seg_size_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      scode_ff    <= scode_in;
      sval_ff     <= sval_in;
      op_ff       <= op_in;
      ri_ff       <= ri_in;
      arg_ff      <= arg_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/tcts_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the toy CPU time slice unit, bound to the top level.
// Depends on tcts_pkg and toy_cpu_time_slice_unit.

module tcts_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tcts_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import tcts_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one command in flight: no request taken right after a transfer
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a command is in flight");

   // read value only on plain completion
   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != ST_DONE) |-> (rsp_tdata[34:3] == 32'd0))
      else $error("read value set on a run result");

   // syscall fields only on syscall status
   a_sysc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != ST_SYSC)
         |-> (rsp_tdata[114:99] == 16'd0) && (rsp_tdata[146:115] == 32'd0))
      else $error("syscall fields set without syscall status");

   // reset empties the result register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind toy_cpu_time_slice_unit tcts_checker u_tcts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb_toy_cpu_time_slice_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for toy_cpu_time_slice_unit: random commands and programs on the
// req stream, each rsp transfer checked against an in-bench model of the CPU state.
// Depends on tcts_pkg and the RTL top level.

module tb_toy_cpu_time_slice_unit;
   import tcts_pkg::*;

   // one command as it travels on req_tdata
   typedef struct packed {
      cmd_type     cmd;
      logic [6:0]  addr;
      logic [3:0]  sel;
      logic [31:0] value;
   } cpu_command;

   // one result as it travels on rsp_tdata
   typedef struct packed {
      status_type  status;
      logic [31:0] read_value;
      logic [31:0] pc;
      logic [31:0] acc;
      logic [15:0] sys_code;
      logic [31:0] sys_value;
   } cpu_result;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we = 1'b0;
   logic                   csr_index = 1'b0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // CPU image kept by the bench; memory is filled before any slice runs
   logic [31:0] mem_image [MEM_WORDS];
   logic [31:0] reg_image [REG_COUNT];
   logic [31:0] pc_image = '0;
   logic [31:0] acc_image = '0;
   logic [6:0]  seg_base_image = '0;
   logic [7:0]  seg_size_image = 8'd128;

   cpu_command queued_commands [$];   // waiting to be offered on req
   cpu_command offered_cmd;           // the one currently on req_tdata
   cpu_result  awaited_results [$];   // predicted, not yet seen on rsp
   cpu_result  awaited;
   int         fault_count = 0;
   bit         quiet = 1'b0;          // when set neither side idles

   // per-phase segment settings; the last phase draws its own
   int phase_base [8] = '{0, 127, 5, 64, 0, 127, 3, 0};
   int phase_size [8] = '{128, 128, 0, 1, 16, 200, 40, 0};

   toy_cpu_time_slice_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      for (int k = 0; k < REG_COUNT; k++) reg_image[k] = '0;
      for (int k = 0; k < MEM_WORDS; k++) mem_image[k] = '0;
   end

   // ---------------------------------------------------------------------------------
   // Model of the CPU
   // ---------------------------------------------------------------------------------

   // negative offsets count as far out of range
   function automatic bit outside_segment(input logic [31:0] off);
      return off[31] || (off >= {24'b0, seg_size_image});
   endfunction

   // base + offset, wrapped to the memory size
   function automatic logic [6:0] segment_word(input logic [31:0] off);
      return 7'(off + {25'b0, seg_base_image});
   endfunction

   function automatic cpu_result execute_command(input cpu_command c);
      cpu_result   r;
      logic [31:0] word;
      logic [31:0] arg;
      logic [31:0] sum;
      logic [7:0]  op;
      logic [2:0]  ri;
      logic [2:0]  rj;
      int          n;
      r = '0;
      r.status = ST_DONE;
      case (c.cmd)
         CMD_WMEM: mem_image[c.addr] = c.value;
         CMD_WREG: begin
            if (c.sel < SEL_PC) reg_image[c.sel[2:0]] = c.value;
            else if (c.sel == SEL_PC) pc_image = c.value;
            else if (c.sel == SEL_ACC) acc_image = c.value;
         end
         CMD_RREG: begin
            if (c.sel < SEL_PC) r.read_value = reg_image[c.sel[2:0]];
            else if (c.sel == SEL_PC) r.read_value = pc_image;
            else if (c.sel == SEL_ACC) r.read_value = acc_image;
         end
         CMD_RUN: begin
            r.status = ST_CLOCK;
            for (n = 0; n < SLICE_LEN; n++) begin
               if (outside_segment(pc_image)) begin
                  r.status = ST_SEGV;
                  break;
               end
               word = mem_image[segment_word(pc_image)];
               op   = word[31:24];
               // register fields taken modulo the register count
               ri   = word[22:20];
               rj   = word[18:16];
               arg  = {{16{word[15]}}, word[15:0]};
               sum  = reg_image[rj] + arg;
               case (op)
                  OP_ADD: begin
                     reg_image[ri] = reg_image[ri] + sum;
                     acc_image = reg_image[ri];
                     pc_image++;
                  end
                  OP_SUB: begin
                     reg_image[ri] = reg_image[ri] - sum;
                     acc_image = reg_image[ri];
                     pc_image++;
                  end
                  OP_CMP: begin
                     acc_image = reg_image[ri] - sum;
                     pc_image++;
                  end
                  OP_IFGT: begin
                     if (!acc_image[31] && acc_image != 0) pc_image = arg;
                     else pc_image++;
                  end
                  OP_NOP, OP_HALT: pc_image++;
                  OP_JUMP: pc_image = arg;
                  OP_SYSC: begin
                     r.status    = ST_SYSC;
                     r.sys_code  = arg[15:0];
                     r.sys_value = reg_image[ri];
                     pc_image++;
                     break;
                  end
                  OP_LOAD: begin
                     // offset left in ACC when the load faults
                     acc_image = sum;
                     if (outside_segment(sum)) begin
                        r.status = ST_SEGV;
                        break;
                     end
                     acc_image = mem_image[segment_word(sum)];
                     reg_image[ri] = acc_image;
                     pc_image++;
                  end
                  default: begin
                     r.status = ST_ILL;
                     break;
                  end
               endcase
            end
         end
      endcase
      r.pc  = pc_image;
      r.acc = acc_image;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   // Random instruction, biased so jumps and loads mostly land inside the segment
   function automatic logic [31:0] make_instruction();
      logic [7:0]  op;
      logic [15:0] arg;
      int          pick;
      int          span;
      span = int'(seg_size_image) + 2;
      pick = $urandom_range(0, 19);
      if (pick < 2) op = OP_ADD;
      else if (pick < 4) op = OP_SUB;
      else if (pick < 5) op = OP_CMP;
      else if (pick < 7) op = OP_IFGT;
      else if (pick < 8) op = OP_NOP;
      else if (pick < 10) op = OP_JUMP;
      else if (pick < 11) op = OP_HALT;
      else if (pick < 13) op = OP_SYSC;
      else if (pick < 18) op = OP_LOAD;
      else op = 8'($urandom_range(int'(OP_LOAD) + 1, 255));
      arg = 16'($urandom());
      if ((op == OP_JUMP || op == OP_IFGT) && $urandom_range(0, 4) != 0)
         arg = 16'($urandom_range(0, span));
      else if (op == OP_LOAD && $urandom_range(0, 3) != 0)
         arg = 16'(int'($urandom_range(0, span + 2)) - 2);
      else if ((op == OP_ADD || op == OP_SUB || op == OP_CMP) && $urandom_range(0, 1) == 1)
         arg = 16'(int'($urandom_range(0, 8)) - 4);
      return {op, 4'($urandom()), 4'($urandom()), arg};
   endfunction

   task automatic push_cmd(input cmd_type cmd, input logic [6:0] addr,
                           input logic [3:0] sel, input logic [31:0] value);
      cpu_command c;
      c.cmd   = cmd;
      c.addr  = addr;
      c.sel   = sel;
      c.value = value;
      queued_commands.push_back(c);
   endtask

   // only called with the block idle, so the model's segment can follow at once
   task automatic write_csr(input logic index, input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_SEG_BASE) seg_base_image = value[6:0];
      else seg_size_image = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // every command yields one result, so an empty result queue means idle
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_commands.size() != 0 || req_tvalid || awaited_results.size() != 0);
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
         fault_count++;
      end
   endtask

   // ---------------------------------------------------------------------------------
   // req driver: a command is modelled at the edge of its transfer, then the next is
   // offered unless this cycle idles. tvalid holds while the block stalls.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_results.push_back(execute_command(offered_cmd));
         if (!req_tvalid || req_tready) begin
            if (queued_commands.size() != 0 && (quiet || $urandom_range(99) >= 14)) begin
               offered_cmd = queued_commands.pop_front();
               req_tdata  <= {3'b0, offered_cmd.value, offered_cmd.sel,
                              offered_cmd.addr, offered_cmd.cmd};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // rsp monitor: random back-pressure; each transfer against the oldest prediction
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 14);
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result expected none actual %h", $time,
                        rsp_tdata);
               fault_count++;
            end else begin
               awaited = awaited_results.pop_front();
               check_field("status", 32'(awaited.status), 32'(rsp_tdata[2:0]));
               check_field("read_value", awaited.read_value, rsp_tdata[34:3]);
               check_field("pc_out", awaited.pc, rsp_tdata[66:35]);
               check_field("acc_out", awaited.acc, rsp_tdata[98:67]);
               check_field("syscall_code", 32'(awaited.sys_code), 32'(rsp_tdata[114:99]));
               check_field("syscall_value", awaited.sys_value, rsp_tdata[146:115]);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequence: reset, fill memory, directed cases, then random phases per segment
   // ---------------------------------------------------------------------------------
   initial begin
      cpu_command c;
      int         roll;
      int         base;
      int         size;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every word written before the first fetch, so no slice reads stale memory
      for (int a = 0; a < MEM_WORDS; a++)
         push_cmd(CMD_WMEM, 7'(a), 4'($urandom()), make_instruction());

      // directed: operand extremes, selector out of range, each opcode, fetch faults
      push_cmd(CMD_WREG, 7'h7F, 4'd0, 32'h7FFF_FFFF);
      push_cmd(CMD_WREG, 7'h00, 4'd1, 32'h8000_0000);
      push_cmd(CMD_WREG, 7'h00, 4'hF, 32'hFFFF_FFFF);   // selector too big: ignored
      push_cmd(CMD_RREG, 7'h00, 4'hF, 32'h0);
      push_cmd(CMD_WREG, 7'h00, SEL_ACC, 32'hFFFF_FFFF);
      push_cmd(CMD_RREG, 7'h00, SEL_ACC, 32'h0);
      push_cmd(CMD_WMEM, 7'd0, 4'd0, {OP_ADD, 4'd2, 4'd0, 16'h0001});   // wraps R0+1
      push_cmd(CMD_WMEM, 7'd1, 4'd0, {OP_SUB, 4'd3, 4'd1, 16'hFFFF});
      push_cmd(CMD_WMEM, 7'd2, 4'd0, {OP_CMP, 4'd2, 4'hB, 16'h0000});   // j wraps to R3
      push_cmd(CMD_WMEM, 7'd3, 4'd0, {OP_IFGT, 8'h00, 16'h0005});
      push_cmd(CMD_WMEM, 7'd4, 4'd0, {OP_NOP, 24'h0});
      push_cmd(CMD_WMEM, 7'd5, 4'd0, {OP_LOAD, 4'd4, 4'd5, 16'd127});  // last word
      push_cmd(CMD_WMEM, 7'd6, 4'd0, {OP_SYSC, 4'hF, 4'd0, 16'h8000});
      push_cmd(CMD_WMEM, 7'd7, 4'd0, {OP_HALT, 24'h0});
      push_cmd(CMD_WMEM, 7'd8, 4'd0, {OP_JUMP, 8'h00, 16'd10});
      push_cmd(CMD_WMEM, 7'd9, 4'd0, 32'hFFFF_FFFF);                    // illegal opcode
      push_cmd(CMD_WMEM, 7'd10, 4'd0, {OP_LOAD, 4'd4, 4'd1, 16'h0});    // negative offset
      push_cmd(CMD_WREG, 7'h00, SEL_PC, 32'd0);
      repeat (4) push_cmd(CMD_RUN, 7'h00, 4'd0, 32'h0);
      push_cmd(CMD_WREG, 7'h00, SEL_PC, 32'd9);
      push_cmd(CMD_RUN, 7'h00, 4'd0, 32'h0);
      push_cmd(CMD_WREG, 7'h00, SEL_PC, 32'hFFFF_FFFF);                 // fetch below zero
      push_cmd(CMD_RUN, 7'h00, 4'd0, 32'h0);
      push_cmd(CMD_RREG, 7'h00, SEL_PC, 32'h0);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         base = phase_base[p];
         size = phase_size[p];
         if (p == 7) begin
            base = $urandom_range(0, 127);
            size = $urandom_range(0, 128);
         end
         write_csr(CSR_SEG_BASE, 8'(base));
         write_csr(CSR_SEG_SIZE, 8'(size));
         quiet = (p == 4);   // one long stretch with no idling on either side
         @(negedge clock);

         // mostly slices, with program rewrites and PC resets to keep them going
         for (int k = 0; k < 200; k++) begin
            roll    = $urandom_range(0, 99);
            c.addr  = 7'($urandom());
            c.sel   = 4'($urandom());
            c.value = $urandom();
            if (roll < 45) begin
               c.cmd = CMD_RUN;
            end else if (roll < 65) begin
               c.cmd = CMD_WMEM;
               if ($urandom_range(0, 6) != 0) c.value = make_instruction();
            end else if (roll < 88) begin
               c.cmd = CMD_WREG;
               roll  = $urandom_range(0, 9);
               if (roll < 4) begin
                  c.sel = SEL_PC;
                  if ($urandom_range(0, 7) != 0)
                     c.value = $urandom_range(0, int'(seg_size_image) + 1);
               end else if (roll < 5) begin
                  c.sel = SEL_ACC;
               end else if (roll < 9) begin
                  c.sel = 4'($urandom_range(0, REG_COUNT - 1));
                  if ($urandom_range(0, 4) < 3)
                     c.value = 32'(int'($urandom_range(0, 140)) - 8);
               end
            end else begin
               c.cmd = CMD_RREG;
               if ($urandom_range(0, 3) != 0) c.sel = 4'($urandom_range(0, 9));
            end
            queued_commands.push_back(c);
         end
         wait_drained();
      end
      quiet = 1'b0;

      // let any stray result surface before the verdict
      repeat (40) @(posedge clock);
      if (fault_count == 0)
         $display("toy_cpu_time_slice_unit: match");
      else
         $display("toy_cpu_time_slice_unit: mismatch");
      $finish;
   end

   // watchdog: a hung handshake ends the run as a failure
   initial begin
      #1_000_000;
      $display("toy_cpu_time_slice_unit: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/tcts_pkg.sv
rtl/toy_cpu_time_slice_unit.sv
rtl/tcts_checker.sv
test/tb_toy_cpu_time_slice_unit.sv
